### sv/mcr_pkg.sv
// Shared types and constants for the Moravec corner response core.
package mcr_pkg;

   // Geometry
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int LINE_ROWS     = 4;
   localparam int PIX_W         = 8;
   localparam int LINE_W        = PIX_W * LINE_ROWS;
   localparam int WIN           = 5;
   localparam int MARGIN        = 2;
   localparam int COORD_W       = 10;
   localparam int DIM_W         = 11;
   localparam int DIM_MIN       = 5;
   localparam int DIM_MAX       = 1024;

   // Arithmetic widths: one square, three squares, nine squares
   localparam int SQ_W          = 2 * PIX_W;
   localparam int PAIR_W        = SQ_W + 2;
   localparam int CONF_W        = 20;

   // Queue between front and back
   localparam int QUEUE_DEPTH   = 4;
   localparam int PTR_W         = $clog2(QUEUE_DEPTH);
   localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 20;

   localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RST      = 11'd640;
   localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RST     = 11'd480;
   localparam logic [CONF_W-1:0] CORNER_THRESHOLD_RST = 20'd15000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH      = 2'd0,
      CSR_IMAGE_HEIGHT     = 2'd1,
      CSR_CORNER_THRESHOLD = 2'd2
   } csr_index_type;

   typedef logic [PIX_W-1:0] pix_type;
   // one window column, index is the window row (WIN-1 = newest row)
   typedef pix_type [WIN-1:0] col_type;
   // the whole window, index is the window column (WIN-1 = newest column)
   typedef col_type [WIN-1:0] win_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             start_of_frame;
   } req_word_type;

   typedef struct packed {
      logic [CONF_W-1:0]  confidence;
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic               is_corner;
      logic               end_of_frame;
   } rsp_word_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic               interior;
      logic               end_of_frame;
   } meta_type;

   typedef struct packed {
      win_type  window;
      meta_type meta;
   } entry_type;

endpackage

### sv/mcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mcr_front.sv
// Front end: pixel position tracking, line store, 5x5 window and result classification.
module mcr_front import mcr_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   input  logic [DIM_W-1:0]   image_width,
   input  logic [DIM_W-1:0]   image_height,
   input  logic [CNT_W-1:0]   queue_count,
   output logic               push_valid,
   output entry_type          push_entry
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int LIM   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
   localparam int SUM_W = CNT_W + 1;

   localparam logic [DIM_W-1:0]   W_LIM   = DIM_W'(LIM);
   localparam logic [DIM_W-1:0]   H_LIM   = DIM_W'(DIM_MAX);
   localparam logic [DIM_W-1:0]   D_MIN   = DIM_W'(DIM_MIN);
   localparam logic [COORD_W-1:0] C_MARG  = COORD_W'(MARGIN);
   localparam logic [COORD_W-1:0] C_MARG1 = COORD_W'(MARGIN + 1);

   logic [DIM_W-1:0]   width_eff;
   logic [DIM_W-1:0]   height_eff;
   logic               accept;

   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_start, col_start;
   logic [COORD_W-1:0] row_cur, col_cur;
   logic [DIM_W-1:0]   row_step, col_inc, row_inc;
   logic               col_wrap;

   logic               emit;
   logic [COORD_W-1:0] res_row, res_col;
   logic [DIM_W-1:0]   res_col_ext;
   meta_type           meta;
   logic               hazard;

   logic               f1_valid_ff;
   logic [PIX_W-1:0]   f1_pixel_ff;
   logic [COORD_W-1:0] f1_col_ff;
   logic               f1_emit_ff;
   meta_type           f1_meta_ff;
   logic               f1_haz_ff;
   logic [LINE_W-1:0]  fwd_word_ff;

   logic [LINE_W-1:0]  line_rd;
   logic [LINE_W-1:0]  line_cur;
   logic [LINE_W-1:0]  line_wr;
   col_type            new_col;
   win_type            win_ff, win_in;

   // clamp the geometry registers
   always_comb begin
      if (image_width < D_MIN) begin
         width_eff = D_MIN;
      end else if (image_width > W_LIM) begin
         width_eff = W_LIM;
      end else begin
         width_eff = image_width;
      end
      if (image_height < D_MIN) begin
         height_eff = D_MIN;
      end else if (image_height > H_LIM) begin
         height_eff = H_LIM;
      end else begin
         height_eff = image_height;
      end
   end

   // room for the word in flight plus the new one
   assign req_stall = ({1'b0, queue_count} + SUM_W'(f1_valid_ff)) >= SUM_W'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   // position of the incoming pixel
   always_comb begin
      row_start = req_word.start_of_frame ? '0 : row_ff;
      col_start = req_word.start_of_frame ? '0 : col_ff;
      col_wrap  = {1'b0, col_start} >= width_eff;
      col_cur   = col_wrap ? '0 : col_start;
      row_step  = {1'b0, row_start} + DIM_W'(col_wrap);
      row_cur   = (row_step >= height_eff) ? '0 : row_step[COORD_W-1:0];
   end

   // position of the pixel after it
   always_comb begin
      col_inc = {1'b0, col_cur} + DIM_W'(1);
      row_inc = {1'b0, row_cur} + DIM_W'(1);
      if (col_inc >= width_eff) begin
         col_in = '0;
         row_in = (row_inc >= height_eff) ? '0 : row_inc[COORD_W-1:0];
      end else begin
         col_in = col_inc[COORD_W-1:0];
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // result classification: the window center trails by two rows and two columns
   always_comb begin
      emit = (row_cur > C_MARG) || ((row_cur == C_MARG) && (col_cur >= C_MARG));
      res_col_ext = width_eff - DIM_W'(MARGIN) + {1'b0, col_cur};
      if (col_cur >= C_MARG) begin
         res_row = row_cur - C_MARG;
         res_col = col_cur - C_MARG;
      end else begin
         // center sits at the end of the previous row
         res_row = row_cur - C_MARG1;
         res_col = res_col_ext[COORD_W-1:0];
      end
      meta.out_row      = res_row;
      meta.out_col      = res_col;
      meta.interior     = (res_row >= C_MARG)
                          && (({1'b0, res_row} + DIM_W'(MARGIN + 1)) <= height_eff)
                          && (res_col >= C_MARG)
                          && (({1'b0, res_col} + DIM_W'(MARGIN + 1)) <= width_eff);
      meta.end_of_frame = ({1'b0, row_cur} == (height_eff - DIM_W'(1)))
                          && ({1'b0, col_cur} == (width_eff - DIM_W'(1)));
   end

   // line store read of this column collides with the write of the word ahead
   assign hazard = f1_valid_ff && (f1_col_ff == col_cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_pixel_ff <= req_word.pixel_value;
         f1_col_ff   <= col_cur;
         f1_emit_ff  <= emit;
         f1_meta_ff  <= meta;
         f1_haz_ff   <= hazard;
         fwd_word_ff <= line_wr;
      end
   end

   // four previous rows of each column, newest row in the top byte
   mcr_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (f1_valid_ff),
      .wr_addr (AW'(f1_col_ff)),
      .wr_data (line_wr),
      .rd_addr (AW'(col_cur)),
      .rd_data (line_rd)
   );

   // column update: new pixel enters on top, the oldest row drops out
   always_comb begin
      line_cur = f1_haz_ff ? fwd_word_ff : line_rd;
      line_wr  = {f1_pixel_ff, line_cur[LINE_W-1:PIX_W]};
      new_col  = col_type'({f1_pixel_ff, line_cur});
   end

   // 5x5 window shift
   always_comb begin
      win_in = win_ff;
      if (f1_valid_ff) begin
         for (int k = 0; k < WIN - 1; k++) begin
            win_in[k] = win_ff[k+1];
         end
         win_in[WIN-1] = new_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   assign push_valid        = f1_valid_ff && f1_emit_ff;
   assign push_entry.window = win_in;
   assign push_entry.meta   = f1_meta_ff;

endmodule

### sv/mcr_queue.sv
// Short word queue between the front end and the arithmetic back end.
module mcr_queue import mcr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  entry_type        push_entry,
   input  logic             pop,
   output logic             pop_valid,
   output entry_type        pop_entry,
   output logic [CNT_W-1:0] count
);

   entry_type        entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign count_in = count_ff + CNT_W'(push_valid) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### sv/mcr_back.sv
// Back end: squared differences, four shift sums, minimum and output register.
module mcr_back import mcr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  entry_type         pop_entry,
   output logic              pop,
   input  logic [CONF_W-1:0] corner_threshold,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_word
);

   // squared difference of two pixels
   function automatic logic [SQ_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   logic               adv;

   // hsq[j][k]: columns j and j+1 at window row k+1
   // vsq[j][i]: window column j+1, rows i and i+1
   logic [SQ_W-1:0]    hsq_in [4][3];
   logic [SQ_W-1:0]    hsq_ff [4][3];
   logic [SQ_W-1:0]    vsq_in [3][4];
   logic [SQ_W-1:0]    vsq_ff [3][4];
   logic [PAIR_W-1:0]  hcol_in [4];
   logic [PAIR_W-1:0]  hcol_ff [4];
   logic [PAIR_W-1:0]  vrow_in [4];
   logic [PAIR_W-1:0]  vrow_ff [4];
   logic [CONF_W-1:0]  sum_in [4];
   logic [CONF_W-1:0]  sum_ff [4];

   logic               b1_valid_ff, b2_valid_ff, b3_valid_ff, rsp_valid_ff;
   meta_type           b1_meta_ff, b2_meta_ff, b3_meta_ff;

   logic [CONF_W-1:0]  min_a, min_b, min_all, conf;
   rsp_word_type       rsp_word_in, rsp_word_ff;

   // whole back pipeline moves unless the output word is held
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && pop_valid;

   // stage 1: squared differences between neighbors
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            hsq_in[j][k] = sq_diff(pop_entry.window[j][k+1], pop_entry.window[j+1][k+1]);
         end
      end
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 4; i++) begin
            vsq_in[j][i] = sq_diff(pop_entry.window[j+1][i], pop_entry.window[j+1][i+1]);
         end
      end
   end

   // stage 2: sums along each column pair and row pair
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         hcol_in[j] = PAIR_W'(hsq_ff[j][0]) + PAIR_W'(hsq_ff[j][1]) + PAIR_W'(hsq_ff[j][2]);
      end
      for (int i = 0; i < 4; i++) begin
         vrow_in[i] = PAIR_W'(vsq_ff[0][i]) + PAIR_W'(vsq_ff[1][i]) + PAIR_W'(vsq_ff[2][i]);
      end
   end

   // stage 3: the four shift sums (right, left, down, up)
   always_comb begin
      sum_in[0] = CONF_W'(hcol_ff[1]) + CONF_W'(hcol_ff[2]) + CONF_W'(hcol_ff[3]);
      sum_in[1] = CONF_W'(hcol_ff[0]) + CONF_W'(hcol_ff[1]) + CONF_W'(hcol_ff[2]);
      sum_in[2] = CONF_W'(vrow_ff[1]) + CONF_W'(vrow_ff[2]) + CONF_W'(vrow_ff[3]);
      sum_in[3] = CONF_W'(vrow_ff[0]) + CONF_W'(vrow_ff[1]) + CONF_W'(vrow_ff[2]);
   end

   // stage 4: minimum, border forcing, threshold
   always_comb begin
      min_a   = (sum_ff[1] < sum_ff[0]) ? sum_ff[1] : sum_ff[0];
      min_b   = (sum_ff[3] < sum_ff[2]) ? sum_ff[3] : sum_ff[2];
      min_all = (min_b < min_a) ? min_b : min_a;
      conf    = b3_meta_ff.interior ? min_all : '0;
      rsp_word_in.confidence   = conf;
      rsp_word_in.out_row      = b3_meta_ff.out_row;
      rsp_word_in.out_col      = b3_meta_ff.out_col;
      rsp_word_in.is_corner    = conf >= corner_threshold;
      rsp_word_in.end_of_frame = b3_meta_ff.end_of_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= pop_valid;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         rsp_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hsq_ff      <= hsq_in;
         vsq_ff      <= vsq_in;
         b1_meta_ff  <= pop_entry.meta;
         hcol_ff     <= hcol_in;
         vrow_ff     <= vrow_in;
         b2_meta_ff  <= b1_meta_ff;
         sum_ff      <= sum_in;
         b3_meta_ff  <= b2_meta_ff;
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### sv/moravec_corner_response_core.sv
// Top level of the Moravec corner response core: registers, front end, queue and back end.
//
// Grey pixels stream in raster order, one word per clock unless stalled. For each pixel the
// core returns the smallest of the four axis-shift 3x3 sums of squared differences, with
// its row and column and a corner flag (confidence at or above corner_threshold); pixels
// within two of a border report 0. A result appears once pixel (row+2, col+2) has been
// taken, so the first 2*W+2 pixels of a frame give none and the last 2*W+2 border
// positions of a frame are never reported; end_of_frame marks the result sent with the
// frame's last pixel. Throughput is one pixel per cycle unless stalled, limited by the single
// write and single read port of the line store (MAX_WIDTH words of four packed rows). From
// input accept a result passes the front-end register, the queue, the back-end stages and the
// output register; a four-word queue lets the input keep flowing while a result is held. The
// line store needs no clearing pass after reset. Write the registers only while the core is idle.
module moravec_corner_response_core import mcr_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DIM_W-1:0]  image_width_ff, image_width_in;
   logic [DIM_W-1:0]  image_height_ff, image_height_in;
   logic [CONF_W-1:0] threshold_ff, threshold_in;

   logic              push_valid;
   entry_type         push_entry;
   logic              pop;
   logic              pop_valid;
   entry_type         pop_entry;
   logic [CNT_W-1:0]  queue_count;

   // register writes
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      threshold_in    = threshold_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:      image_width_in  = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:     image_height_in = csr_wdata[DIM_W-1:0];
            CSR_CORNER_THRESHOLD: threshold_in    = csr_wdata[CONF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         threshold_ff    <= CORNER_THRESHOLD_RST;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         threshold_ff    <= threshold_in;
      end
   end

   mcr_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .queue_count  (queue_count),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   mcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .count      (queue_count)
   );

   mcr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_entry        (pop_entry),
      .pop              (pop),
      .corner_threshold (threshold_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word)
   );

endmodule

### bench/moravec_corner_response_core_test.sv
// Self-checking testbench for the Moravec corner response core: random pixel frames checked against an in-bench prediction.
`timescale 1ns / 1ps

import mcr_pkg::*;

// Tracks the core's geometry, line rows and window, and holds the responses still due
class corner_checker;
   logic [DIM_W-1:0]  width_reg;
   logic [DIM_W-1:0]  height_reg;
   logic [CONF_W-1:0] threshold_reg;
   pix_type           line_rows[LINE_ROWS][MAX_WIDTH_DEF];
   col_type           window_cols[WIN];
   // line rows written since reset, and window cells with defined data (reset zero or such rows)
   bit                line_known[LINE_ROWS][MAX_WIDTH_DEF];
   bit                window_known[WIN][WIN];
   int unsigned       row_pos;
   int unsigned       col_pos;
   rsp_word_type      due_responses[$];
   bit                due_exact[$];
   int unsigned       errors;

   function new();
      width_reg     = IMAGE_WIDTH_RST;
      height_reg    = IMAGE_HEIGHT_RST;
      threshold_reg = CORNER_THRESHOLD_RST;
      foreach (line_rows[k, c]) line_rows[k][c] = '0;
      foreach (window_cols[k]) window_cols[k] = '0;
      foreach (line_known[k, c]) line_known[k][c] = 1'b0;
      foreach (window_known[k, r]) window_known[k][r] = 1'b1;
      row_pos = 0;
      col_pos = 0;
      errors  = 0;
   endfunction

   function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_IMAGE_WIDTH:      width_reg = val[DIM_W-1:0];
         CSR_IMAGE_HEIGHT:     height_reg = val[DIM_W-1:0];
         CSR_CORNER_THRESHOLD: threshold_reg = val[CONF_W-1:0];
         default: ;
      endcase
   endfunction

   // Geometry in use: out-of-range values are clamped
   function int unsigned active_width();
      if (width_reg < DIM_MIN) return DIM_MIN;
      if (width_reg > DIM_MAX || width_reg > MAX_WIDTH_DEF) return DIM_MAX;
      return width_reg;
   endfunction

   function int unsigned active_height();
      if (height_reg < DIM_MIN) return DIM_MIN;
      if (height_reg > DIM_MAX) return DIM_MAX;
      return height_reg;
   endfunction

   // 3x3 sum of squared differences against the window moved by (dx, dy)
   function int unsigned window_energy(int dx, int dy);
      int unsigned acc;
      int          d;
      acc = 0;
      for (int u = -1; u <= 1; u++) begin
         for (int v = -1; v <= 1; v++) begin
            d = int'(window_cols[2 + u][2 + v]) - int'(window_cols[2 + u + dx][2 + v + dy]);
            acc += d * d;
         end
      end
      return acc;
   endfunction

   // One accepted pixel word: advance position, stores and window, queue any response
   function void take_pixel(req_word_type word);
      int unsigned  wd, ht, r, c, yr, xr, conf, energy;
      col_type      fresh;
      bit           fresh_known[WIN];
      bit           exact;
      rsp_word_type want;
      wd = active_width();
      ht = active_height();
      if (word.start_of_frame) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (col_pos >= wd) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= ht) row_pos = 0;
      r = row_pos;
      c = col_pos;

      // newest pixel on top, previous rows below it
      fresh[WIN-1] = word.pixel_value;
      fresh_known[WIN-1] = 1'b1;
      for (int k = 0; k < LINE_ROWS; k++) begin
         fresh[LINE_ROWS-1-k]       = line_rows[k][c];
         fresh_known[LINE_ROWS-1-k] = line_known[k][c];
      end
      for (int k = LINE_ROWS - 1; k > 0; k--) begin
         line_rows[k][c]  = line_rows[k-1][c];
         line_known[k][c] = line_known[k-1][c];
      end
      line_rows[0][c]  = word.pixel_value;
      line_known[0][c] = 1'b1;
      for (int k = 0; k < WIN - 1; k++) begin
         window_cols[k]  = window_cols[k+1];
         window_known[k] = window_known[k+1];
      end
      window_cols[WIN-1]  = fresh;
      window_known[WIN-1] = fresh_known;

      if (r * wd + c >= 2 * wd + 2) begin
         if (c >= 2) begin
            yr = r - 2;
            xr = c - 2;
         end else begin
            yr = r - 3;
            xr = wd - 2 + c;
         end
         conf  = 0;
         exact = 1'b1;
         if (yr >= 2 && yr + 3 <= ht && xr >= 2 && xr + 3 <= wd) begin
            conf = window_energy(1, 0);
            energy = window_energy(0, 1);
            if (energy < conf) conf = energy;
            energy = window_energy(-1, 0);
            if (energy < conf) conf = energy;
            energy = window_energy(0, -1);
            if (energy < conf) conf = energy;
            // a sum that reads a never-written line row has no defined value
            for (int cx = 0; cx < WIN; cx++) begin
               for (int ry = 0; ry < WIN; ry++) begin
                  if (!window_known[cx][ry] &&
                      ((cx > 0 && cx < WIN - 1) || (ry > 0 && ry < WIN - 1))) exact = 1'b0;
               end
            end
         end
         want.confidence   = CONF_W'(conf);
         want.out_row      = COORD_W'(yr);
         want.out_col      = COORD_W'(xr);
         want.is_corner    = (conf >= threshold_reg);
         want.end_of_frame = (r == ht - 1 && c == wd - 1);
         due_responses.push_back(want);
         due_exact.push_back(exact);
      end

      col_pos = c + 1;
      if (col_pos >= wd) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= ht) row_pos = 0;
      end
   endfunction

   // One accepted response word against the oldest one due
   function void match_response(rsp_word_type got);
      rsp_word_type want;
      bit           exact;
      if (due_responses.size() == 0) begin
         $error("response with none due: row %0d col %0d confidence %0d",
                got.out_row, got.out_col, got.confidence);
         errors++;
         return;
      end
      want  = due_responses.pop_front();
      exact = due_exact.pop_front();
      if (exact && got.confidence !== want.confidence) begin
         $error("confidence: expected %0d, actual %0d", want.confidence, got.confidence);
         errors++;
      end
      if (got.out_row !== want.out_row) begin
         $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
         errors++;
      end
      if (got.out_col !== want.out_col) begin
         $error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
         errors++;
      end
      if (exact && got.is_corner !== want.is_corner) begin
         $error("is_corner: expected %0b, actual %0b", want.is_corner, got.is_corner);
         errors++;
      end
      if (got.end_of_frame !== want.end_of_frame) begin
         $error("end_of_frame: expected %0b, actual %0b", want.end_of_frame, got.end_of_frame);
         errors++;
      end
   endfunction

   function int unsigned outstanding();
      return due_responses.size();
   endfunction
endclass

module moravec_corner_response_core_test;
   localparam int unsigned LIMIT_CYCLES  = 5_000_000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned RANDOM_WORDS  = 600;

   typedef enum int unsigned {
      TEXTURE_NOISE,
      TEXTURE_CHECKER,
      TEXTURE_RAMP,
      TEXTURE_BLOCKS
   } texture_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_word_type  req_word;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_word_type  rsp_word;
   logic          csr_wr_en;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   corner_checker tracker;
   int unsigned   words_sent = 0;
   int unsigned   cycle_count = 0;
   int unsigned   stall_hold = 0;

   moravec_corner_response_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Output back-pressure: short and long stalls, with open stretches
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         case ($urandom_range(0, 15))
            0: begin
               rsp_stall  <= 1'b0;
               stall_hold <= $urandom_range(100, 400);
            end
            1: begin
               rsp_stall  <= 1'b1;
               stall_hold <= $urandom_range(20, 60);
            end
            2, 3, 4, 5: begin
               rsp_stall  <= 1'b1;
               stall_hold <= $urandom_range(0, 3);
            end
            default: begin
               rsp_stall  <= 1'b0;
               stall_hold <= $urandom_range(0, 4);
            end
         endcase
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_response(rsp_word);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic pix_type make_pixel(texture_type tex, int unsigned r, int unsigned c);
      case (tex)
         TEXTURE_CHECKER: begin
            if ($urandom_range(0, 15) == 0) return pix_type'($urandom_range(0, 255));
            return ((r + c) % 2 != 0) ? 8'hFF : 8'h00;
         end
         TEXTURE_RAMP: return pix_type'(r * 9 + c * 5 + $urandom_range(0, 3));
         TEXTURE_BLOCKS: begin
            if ((r / 3 + c / 4) % 2 != 0) return pix_type'(200 + $urandom_range(0, 20));
            return pix_type'($urandom_range(0, 40));
         end
         default: return pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Holds the word until the core takes it
   task automatic send_word(req_word_type word);
      req_valid <= 1'b1;
      req_word  <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_pixel(word);
      words_sent++;
   endtask

   // Sender gaps before a word; now and then wait for every response to drain
   task automatic pace_sender(bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll == 0) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (tracker.outstanding() != 0);
      end else if (!calm && roll < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(20, 60)) @(posedge clock);
      end else if (!calm && roll < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Idle the sender until nothing is due, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers back to back
   task automatic program_regs(int unsigned wd, int unsigned ht, int unsigned thr);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(wd);
      @(posedge clock);
      tracker.set_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(wd));
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(ht);
      @(posedge clock);
      tracker.set_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(ht));
      csr_index <= CSR_CORNER_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(thr);
      @(posedge clock);
      tracker.set_reg(CSR_CORNER_THRESHOLD, CSR_DATA_W'(thr));
      csr_wr_en <= 1'b0;
   endtask

   // Streams count pixels of a frame of row length wd
   task automatic stream_frame(int unsigned wd, int unsigned count, bit mark_start, bit calm,
                               texture_type tex, bit stray_marks);
      int unsigned  r, c;
      req_word_type word;
      r = 0;
      c = 0;
      for (int unsigned n = 0; n < count; n++) begin
         word.pixel_value    = make_pixel(tex, r, c);
         word.start_of_frame = (n == 0 && mark_start) ||
                               (stray_marks && $urandom_range(0, 499) == 0);
         pace_sender(calm);
         send_word(word);
         c++;
         if (c >= wd) begin
            c = 0;
            r++;
         end
      end
   endtask

   // Small random geometry and threshold, a frame or two, some cut short or unmarked
   task automatic run_random_phase();
      int unsigned wd, ht, thr, wd_eff, ht_eff, frames, count, pick;
      bit          calm, mark;
      texture_type tex;
      settle();
      pick = $urandom_range(0, 19);
      if (pick == 0) wd = $urandom_range(0, 4);
      else if (pick < 4) wd = $urandom_range(13, 40);
      else wd = $urandom_range(5, 12);
      ht = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9);
      case ($urandom_range(0, 5))
         0: thr = 0;
         1: thr = $urandom_range(0, 5000);
         2: thr = $urandom_range(585225, 1048575);
         3: thr = CORNER_THRESHOLD_RST;
         default: thr = $urandom_range(0, 585225);
      endcase
      program_regs(wd, ht, thr);
      wd_eff = (wd < DIM_MIN) ? DIM_MIN : wd;
      ht_eff = (ht < DIM_MIN) ? DIM_MIN : ht;
      frames = $urandom_range(1, 2);
      calm   = ($urandom_range(0, 3) == 0);
      for (int unsigned f = 0; f < frames; f++) begin
         tex   = texture_type'($urandom_range(0, 3));
         count = wd_eff * ht_eff;
         if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count - 1);
         // an unmarked first frame picks up wherever the counts stand
         mark = (f == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) != 0);
         stream_frame(wd_eff, count, mark, calm, tex, 1'b1);
      end
   endtask

   initial begin
      req_word_type word;
      int unsigned  base;
      tracker   = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // 5x5 frame from clamped geometry, pure checkerboard, threshold at the top value
      program_regs(3, 0, 585225);
      for (int unsigned n = 0; n < 25; n++) begin
         word.pixel_value    = ((n / 5 + n % 5) % 2 != 0) ? 8'hFF : 8'h00;
         word.start_of_frame = (n == 0);
         send_word(word);
      end
      settle();

      base = words_sent;
      while (words_sent - base < RANDOM_WORDS) run_random_phase();
      settle();

      if (tracker.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
